FILE: hdl/brbc_pkg.sv
// Shared types and constants for the chunked byte ring buffer.
package brbc_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned MAX_READ_RUN    = 64;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned FILL_W = 11;
  localparam int unsigned CAP_W  = 11;

  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PADDR_W-1:0] REG_CAPACITY_ADDR = 2'd0;
  localparam logic [CAP_W-1:0]   CAPACITY_RESET    = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 3'd0,
    FUNC_POP     = 3'd1,
    FUNC_DISCARD = 3'd2,
    FUNC_PEEK    = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STREAM
  } ctl_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_in;
    logic              chunk_end;
    logic [LEN_W-1:0]  length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              has_byte;
    logic              status;
    logic [FILL_W-1:0] fill_level;
    logic              last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // capture the input beat
    logic exec_single;  // run a one-result operation
    logic start_stream; // start a pop/peek stream, issue the first read; a pop commits
    logic emit;         // move one read byte to the output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_stream;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

endpackage

FILE: hdl/byte_ring_buffer_chunked_core.sv
// Top level of the chunked byte ring buffer: controller, datapath, register port.
// Sequence: a push, discard, clear or refused beat is latched, then its result is loaded into
//   the output register once it is free; a pop or peek of L bytes is latched, then begun with
//   the first store read issued (pops commit), then streamed, one byte per cycle while the
//   output is not stalled, paced by the registered store read; no new beat is taken meanwhile.
// Reset: indices, counts and staging clear, capacity returns to 1024; the store is not cleared.
module byte_ring_buffer_chunked_core #(
  parameter int unsigned STORE_DEPTH = brbc_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  brbc_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output brbc_pkg::out_item_t            out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brbc_pkg::PADDR_W-1:0]   paddr,
  input  logic [brbc_pkg::PDATA_W-1:0]   pwdata,
  output logic [brbc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import brbc_pkg::*;

  ctl_cmd_t          cmd;
  dp_stat_t          stat;
  logic              cfg_wr;
  logic [CAP_W-1:0]  cap;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_CAPACITY_ADDR);
  assign prdata = (paddr == REG_CAPACITY_ADDR) ? PDATA_W'(cap) : '0;

  brbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  brbc_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cfg_wr_i    (cfg_wr),
    .cfg_wdata_i (pwdata[CAP_W-1:0]),
    .cap_o       (cap)
  );

  // one beat at a time: after an accept the block is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous beat still in progress");

  a_emit_loads_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o && out_item_o.has_byte)
    else $error("streamed byte did not reach the output register");

  a_byte_not_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.has_byte |-> !out_item_o.status)
    else $error("returned byte flagged as refused");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_item_o.fill_level) <= STORE_DEPTH)
    else $error("fill level exceeds store depth");

endmodule

FILE: hdl/brbc_ram.sv
// Generic single-port RAM with registered read data.
module brbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/brbc_ctrl.sv
// Sequencing state machine for the chunked byte ring buffer.
module brbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brbc_pkg::dp_stat_t  stat_i,
  output brbc_pkg::ctl_cmd_t  cmd_o
);
  import brbc_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.is_stream) begin
          cmd_o.start_stream = 1'b1;
          state_d            = ST_STREAM;
        end else if (stat_i.out_free) begin
          cmd_o.exec_single = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/brbc_dpath.sv
// Datapath: ring indices, counts, byte store and output register.
module brbc_dpath #(
  parameter int unsigned STORE_DEPTH = brbc_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brbc_pkg::in_item_t            in_item_i,
  input  brbc_pkg::ctl_cmd_t            cmd_i,
  output brbc_pkg::dp_stat_t            stat_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output brbc_pkg::out_item_t           out_item_o,
  input  logic                          cfg_wr_i,
  input  logic [brbc_pkg::CAP_W-1:0]    cfg_wdata_i,
  output logic [brbc_pkg::CAP_W-1:0]    cap_o
);
  import brbc_pkg::*;

  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  // base < cap and off <= cap, so one conditional subtract wraps it
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [CW-1:0] off,
                                             logic [CW-1:0] cap);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(cap)) begin
      sum = sum - (CW+1)'(cap);
    end
    return IW'(sum);
  endfunction

  in_item_t        item_q;
  logic [CAP_W-1:0] cap_q;
  logic [IW-1:0]   rd_idx_q, wr_idx_q, rd_ptr_q;
  logic [CW-1:0]   stored_q, staged_q, fill_q;
  logic            ovf_q;
  logic [LEN_W-1:0] cnt_q, len_q;
  logic            out_valid_q;
  out_item_t       out_item_q;

  logic [CAP_W-1:0] cap_raw;
  logic [CW-1:0]   cap_eff;
  logic [CW:0]     occ;
  logic            can_stage, ovf_n;
  logic [CW-1:0]   staged_n;
  logic [IW-1:0]   wr_pos, commit_idx, rd_adv, ptr_nxt;
  logic            refused, emit_last, out_free;
  logic            res_status;
  logic [CW-1:0]   res_fill;
  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  // capacity clamp: 0 acts as 1, anything above the store acts as its depth
  always_comb begin
    cap_raw = (cap_q == '0) ? CAP_W'(1) : cap_q;
    if (32'(cap_raw) > STORE_DEPTH) begin
      cap_eff = CW'(STORE_DEPTH);
    end else begin
      cap_eff = CW'(cap_raw);
    end
  end

  assign occ        = (CW+1)'(stored_q) + (CW+1)'(staged_q);
  assign can_stage  = !ovf_q && (occ < (CW+1)'(cap_eff));
  assign ovf_n      = ovf_q | ~can_stage;
  assign staged_n   = staged_q + CW'(can_stage);
  assign wr_pos     = wrap_add(wr_idx_q, staged_q, cap_eff);
  assign commit_idx = wrap_add(wr_idx_q, staged_n, cap_eff);
  assign rd_adv     = wrap_add(rd_idx_q, CW'(item_q.length), cap_eff);
  assign ptr_nxt    = wrap_add(rd_ptr_q, CW'(1), cap_eff);

  assign refused = (item_q.length == '0) || (32'(item_q.length) > MAX_READ_RUN) ||
                   (32'(item_q.length) > 32'(stored_q));

  assign emit_last = ((cnt_q + LEN_W'(1)) == len_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign stat_o.is_stream = ((item_q.func == FUNC_POP) || (item_q.func == FUNC_PEEK)) &&
                            !refused;
  assign stat_o.out_free  = out_free;
  assign stat_o.emit_last = emit_last;

  // status and fill of a one-result operation
  always_comb begin
    res_status = 1'b0;
    res_fill   = stored_q;
    case (item_q.func)
      FUNC_PUSH: begin
        res_status = ovf_n;
        if (item_q.chunk_end && !ovf_n) begin
          res_fill = stored_q + staged_n;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        res_status = 1'b1;
      end
      FUNC_DISCARD: begin
        res_status = refused;
        if (!refused) begin
          res_fill = stored_q - CW'(item_q.length);
        end
      end
      FUNC_CLEAR: begin
        res_fill = '0;
      end
      default: begin
        res_status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAPACITY_RESET;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      stored_q <= '0;
      staged_q <= '0;
      ovf_q    <= 1'b0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
      fill_q   <= '0;
    end else if (cfg_wr_i) begin
      cap_q    <= cfg_wdata_i;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      stored_q <= '0;
      staged_q <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (cmd_i.exec_single) begin
        case (item_q.func)
          FUNC_PUSH: begin
            if (item_q.chunk_end) begin
              if (!ovf_n) begin
                wr_idx_q <= commit_idx;
                stored_q <= stored_q + staged_n;
              end
              staged_q <= '0;
              ovf_q    <= 1'b0;
            end else begin
              staged_q <= staged_n;
              ovf_q    <= ovf_n;
            end
          end
          FUNC_DISCARD: begin
            if (!refused) begin
              rd_idx_q <= rd_adv;
              stored_q <= stored_q - CW'(item_q.length);
            end
          end
          FUNC_CLEAR: begin
            rd_idx_q <= '0;
            wr_idx_q <= '0;
            stored_q <= '0;
            staged_q <= '0;
            ovf_q    <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.start_stream) begin
        // pop commits up front; the stream runs off its own pointer
        rd_ptr_q <= rd_idx_q;
        cnt_q    <= '0;
        len_q    <= item_q.length;
        if (item_q.func == FUNC_POP) begin
          rd_idx_q <= rd_adv;
          stored_q <= stored_q - CW'(item_q.length);
          fill_q   <= stored_q - CW'(item_q.length);
        end else begin
          fill_q   <= stored_q;
        end
      end
      if (cmd_i.emit && !emit_last) begin
        rd_ptr_q <= ptr_nxt;
        cnt_q    <= cnt_q + LEN_W'(1);
      end
    end
  end

  assign ram_we   = cmd_i.exec_single && (item_q.func == FUNC_PUSH) && can_stage;
  assign ram_re   = cmd_i.start_stream || (cmd_i.emit && !emit_last);
  assign ram_addr = ram_we ? wr_pos : (cmd_i.start_stream ? rd_idx_q : ptr_nxt);

  brbc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (item_q.data_in),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_single || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_single) begin
      out_item_q.data_out   <= '0;
      out_item_q.has_byte   <= 1'b0;
      out_item_q.status     <= res_status;
      out_item_q.fill_level <= FILL_W'(res_fill);
      out_item_q.last       <= 1'b1;
    end else if (cmd_i.emit) begin
      out_item_q.data_out   <= ram_rdata;
      out_item_q.has_byte   <= 1'b1;
      out_item_q.status     <= 1'b0;
      out_item_q.fill_level <= FILL_W'(fill_q);
      out_item_q.last       <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cap_o       = cap_q;

endmodule

FILE: bench/brbc_checker.sv
`timescale 1ns / 100ps
// Checker for the chunked byte ring buffer: watches both channels and the register port,
// predicts every result beat and compares it with what the block sends.
module brbc_checker
  import brbc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_item_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 beat_cnt_o,
  output int                 result_cnt_o,
  output int                 refused_cnt_o
);

  localparam int unsigned DEPTH = STORE_DEPTH_DEF;

  // shadow of the ring
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       stored;
  int unsigned       staged;
  bit                overflow;
  logic [CAP_W-1:0]  cap_reg;

  out_item_t due_results[$];
  int        fails;
  int        beats;
  int        results;
  int        refused;

  function automatic int unsigned cap_now();
    int unsigned c;
    c = 32'(cap_reg);
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned ring_add(int unsigned base, int unsigned off,
                                           int unsigned cap);
    int unsigned s;
    s = (base % cap) + (off % cap);
    if (s >= cap) s -= cap;
    return s;
  endfunction

  function automatic void ring_empty();
    rd_ptr   = 0;
    wr_ptr   = 0;
    stored   = 0;
    staged   = 0;
    overflow = 1'b0;
  endfunction

  // Work out the result beats one request causes and queue them.
  task automatic ring_apply(in_item_t it);
    int unsigned cap;
    int unsigned fill;
    int unsigned pos;
    int unsigned n;
    int unsigned k;
    out_item_t   r;
    cap = cap_now();
    n = 32'(it.length);
    r = '0;
    r.last = 1'b1;
    case (it.func)
      FUNC_PUSH: begin
        if (!overflow && stored + staged < cap) begin
          pos = ring_add(wr_ptr, staged, cap);
          ring_mem[pos] = it.data_in;
          staged++;
        end else begin
          overflow = 1'b1;
        end
        r.status = overflow;
        if (it.chunk_end) begin
          if (!overflow) begin
            wr_ptr = ring_add(wr_ptr, staged, cap);
            stored += staged;
          end
          staged   = 0;
          overflow = 1'b0;
        end
        r.fill_level = FILL_W'(stored);
        due_results.push_back(r);
      end
      FUNC_POP, FUNC_DISCARD, FUNC_PEEK: begin
        if (n == 0 || n > MAX_READ_RUN || n > stored) begin
          r.status     = 1'b1;
          r.fill_level = FILL_W'(stored);
          due_results.push_back(r);
        end else begin
          fill = (it.func == FUNC_PEEK) ? stored : stored - n;
          if (it.func == FUNC_DISCARD) begin
            r.fill_level = FILL_W'(fill);
            due_results.push_back(r);
          end else begin
            for (k = 0; k < n; k++) begin
              r.data_out   = ring_mem[ring_add(rd_ptr, k, cap)];
              r.has_byte   = 1'b1;
              r.fill_level = FILL_W'(fill);
              r.last       = (k + 1 == n);
              due_results.push_back(r);
            end
          end
          if (it.func != FUNC_PEEK) begin
            rd_ptr = ring_add(rd_ptr, n, cap);
            stored = fill;
          end
        end
      end
      FUNC_CLEAR: begin
        ring_empty();
        due_results.push_back(r);
      end
      default: begin
        r.status     = 1'b1;
        r.fill_level = FILL_W'(stored);
        due_results.push_back(r);
      end
    endcase
    if (due_results[$].status) refused++;
  endtask

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    results++;
    if (due_results.size() == 0) begin
      $error("result beat with nothing pending: data_out %0d status %0d fill_level %0d",
             got.data_out, got.status, got.fill_level);
      fails++;
    end else begin
      want = due_results.pop_front();
      field_check("data_out", 32'(want.data_out), 32'(got.data_out));
      field_check("has_byte", 32'(want.has_byte), 32'(got.has_byte));
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("fill_level", 32'(want.fill_level), 32'(got.fill_level));
      field_check("last", 32'(want.last), 32'(got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_reg = CAPACITY_RESET;
      ring_empty();
      due_results.delete();
      fails   = 0;
      beats   = 0;
      results = 0;
      refused = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == REG_CAPACITY_ADDR) begin
        cap_reg = pwdata_i[CAP_W-1:0];
        ring_empty();
      end
      if (in_valid_i && !in_stall_i) begin
        beats++;
        ring_apply(in_item_i);
      end
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
    end
    fail_cnt_o    <= fails;
    pending_o     <= due_results.size();
    beat_cnt_o    <= beats;
    result_cnt_o  <= results;
    refused_cnt_o <= refused;
  end

endmodule

FILE: bench/tb_byte_ring_buffer_chunked_core.sv
`timescale 1ns / 100ps
// Testbench top for the chunked byte ring buffer: stimulus, receiver pacing and verdict.
module tb_byte_ring_buffer_chunked_core;
  import brbc_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int cycle_cnt  = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int stall_left = 0;
  bit quiet      = 1'b0;
  int beats_sent = 0;
  int cap_writes = 0;

  int fail_cnt;
  int pending;
  int beat_cnt;
  int result_cnt;
  int refused_cnt;

  always #5 clk = ~clk;

  byte_ring_buffer_chunked_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  brbc_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .beat_cnt_o    (beat_cnt),
    .result_cnt_o  (result_cnt),
    .refused_cnt_o (refused_cnt)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_read_func();
    case ($urandom_range(0, 2))
      0:       return FUNC_POP;
      1:       return FUNC_DISCARD;
      default: return FUNC_PEEK;
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        stall_left = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one beat and hold it until taken; valid stays high when no gap follows.
  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] d,
                           input logic ce, input logic [LEN_W-1:0] len);
    int gap;
    in_item  <= '{func: f, data_in: d, chunk_end: ce, length: len};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic ce);
    send_beat(FUNC_PUSH, d, ce, LEN_W'($urandom));
  endtask

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [LEN_W-1:0] len);
    send_beat(f, BYTE_W'($urandom), 1'($urandom), len);
  endtask

  // a chunk of random bytes; reads may slip in between its bytes
  task automatic push_chunk(input int n, input int mix_pct);
    int k;
    for (k = 0; k < n; k++) begin
      send_byte(BYTE_W'($urandom), k == n - 1);
      if (k != n - 1 && $urandom_range(0, 99) < mix_pct)
        send_cmd(pick_read_func(), LEN_W'($urandom_range(1, 6)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [PDATA_W-1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CAPACITY_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_writes++;
  endtask

  task automatic random_phase(input int n);
    int start;
    int r;
    int len;
    start = beats_sent;
    while (beats_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_chunk($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 8), 15);
      end else if (r < 80) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(1, 16);
        else if (r < 95) len = $urandom_range(17, MAX_READ_RUN);
        else if (r < 97) len = 0;
        else len = $urandom_range(MAX_READ_RUN + 1, 127);
        send_cmd(pick_read_func(), LEN_W'(len));
      end else if (r < 85) begin
        send_cmd(FUNC_CLEAR, LEN_W'($urandom));
      end else if (r < 92) begin
        send_beat(FUNC_W'($urandom_range(5, 7)), BYTE_W'($urandom), 1'($urandom),
                  LEN_W'($urandom));
      end else begin
        // chunk left open, sometimes cut off by a clear
        repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom), 1'b0);
        if ($urandom_range(0, 1)) send_cmd(FUNC_CLEAR, LEN_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty read, extremes of bytes, refused lengths, unknown func
    send_cmd(FUNC_POP, 7'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_cmd(FUNC_PEEK, 7'd3);
    send_cmd(FUNC_POP, LEN_W'(MAX_READ_RUN));
    send_cmd(FUNC_POP, 7'd0);
    send_cmd(FUNC_POP, 7'd2);
    send_beat(3'd5, 8'h5A, 1'b1, 7'h7F);
    // read of committed bytes while a chunk is staged
    send_byte(8'h3C, 1'b0);
    send_cmd(FUNC_POP, 7'd1);
    send_byte(8'hC3, 1'b1);
    send_cmd(FUNC_CLEAR, 7'h55);

    // tiny ring: wrap-around, space freed mid-chunk, chunk too big
    write_capacity(32'd4);
    push_chunk(3, 0);
    send_byte(8'h81, 1'b0);
    send_cmd(FUNC_POP, 7'd2);
    send_byte(8'h42, 1'b0);
    send_byte(8'h24, 1'b1);
    send_cmd(FUNC_PEEK, 7'd4);
    send_cmd(FUNC_DISCARD, 7'd4);
    push_chunk(5, 0);

    // random: long hold-off with the sender pushing flat out
    write_capacity(32'd1024);
    quiet    <= 1'b1;
    hold_req <= hold_req + 1;
    random_phase(30);
    quiet <= 1'b0;
    random_phase(30);

    write_capacity(32'd0);
    random_phase(30);
    write_capacity(32'd2047);
    random_phase(50);
    write_capacity(32'd1);
    random_phase(30);
    write_capacity(32'd16);
    random_phase(35);
    drain();
    random_phase(35);
    write_capacity(32'd64);
    random_phase(60);
    write_capacity($urandom_range(2, 300));
    random_phase(60);

    drain();
    repeat (TAIL) @(posedge clk);
    $display("covered %0d request beats and %0d result beats over %0d capacity settings",
             beat_cnt, result_cnt, cap_writes + 1);
    $display("%0d requests were refused", refused_cnt);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
